@@ sv/twra_pkg.sv @@
package twra_pkg;

  // Request codes carried in the op field of an input item.
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // Configuration register indexes (byte address 4*index).
  localparam logic REG_DEVICE_ADDRESS = 1'b0;
  localparam logic REG_TIMEOUT_TICKS  = 1'b1;

  // Reset values and fixed constants.
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [7:0]  READ_FLAG     = 8'h80;

  // Entry points into the waveform program.
  localparam logic [6:0] SEND_START = 7'd1;
  localparam logic [6:0] SEND_LOOP  = 7'd14;
  localparam logic [6:0] READ_START = 7'd36;
  localparam logic [6:0] READ_LOOP  = 7'd45;

  // One pin action or wait per program step.
  typedef enum logic [4:0] {
    STEP_IDLE,
    STEP_SCL_HI,
    STEP_SCL_LO,
    STEP_SDA_HI,
    STEP_SDA_LO,
    STEP_TRI,
    STEP_UNTRI,
    STEP_WAIT_SCL,
    STEP_WAIT_SDA,
    STEP_OUT_BIT,
    STEP_NEXT_OUT,
    STEP_ACK1,
    STEP_ACK2,
    STEP_SEND_END,
    STEP_IN_BIT,
    STEP_NEXT_IN,
    STEP_READ_END
  } step_op_t;

  // One result item as it sits in the output buffer.
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       error;
    logic [7:0] read_data;
  } result_t;

  // Waveform program: the action stored at each step position.
  function automatic step_op_t prog_op(input logic [6:0] pos);
    step_op_t op;
    case (pos)
      // Start pattern of a sent byte.
      7'd1:  op = STEP_SDA_HI;
      7'd2:  op = STEP_WAIT_SDA;
      7'd3:  op = STEP_SCL_HI;
      7'd4:  op = STEP_WAIT_SCL;
      7'd5:  op = STEP_SCL_LO;
      7'd6:  op = STEP_SCL_HI;
      7'd7:  op = STEP_WAIT_SCL;
      7'd8:  op = STEP_SCL_LO;
      7'd9:  op = STEP_SDA_LO;
      7'd10: op = STEP_SCL_HI;
      7'd11: op = STEP_WAIT_SCL;
      7'd12: op = STEP_SCL_LO;
      7'd13: op = STEP_SCL_LO;
      // Bit loop of a sent byte.
      7'd14: op = STEP_OUT_BIT;
      7'd15: op = STEP_WAIT_SDA;
      7'd16: op = STEP_SCL_HI;
      7'd17: op = STEP_WAIT_SCL;
      7'd18: op = STEP_NEXT_OUT;
      // Stop pattern.
      7'd19: op = STEP_SDA_HI;
      7'd20: op = STEP_WAIT_SDA;
      7'd21: op = STEP_SCL_HI;
      7'd22: op = STEP_WAIT_SCL;
      7'd23: op = STEP_SCL_LO;
      // Acknowledge clocks.
      7'd24: op = STEP_TRI;
      7'd25: op = STEP_SCL_HI;
      7'd26: op = STEP_WAIT_SCL;
      7'd27: op = STEP_ACK1;
      7'd28: op = STEP_SCL_LO;
      7'd29: op = STEP_SCL_HI;
      7'd30: op = STEP_WAIT_SCL;
      7'd31: op = STEP_ACK2;
      7'd32: op = STEP_SCL_LO;
      7'd33: op = STEP_SCL_HI;
      7'd34: op = STEP_WAIT_SCL;
      7'd35: op = STEP_SEND_END;
      // Read start.
      7'd36: op = STEP_TRI;
      7'd37: op = STEP_SCL_LO;
      7'd38: op = STEP_SCL_HI;
      7'd39: op = STEP_WAIT_SCL;
      7'd40: op = STEP_SCL_LO;
      7'd41: op = STEP_WAIT_SDA;
      7'd42: op = STEP_SCL_HI;
      7'd43: op = STEP_WAIT_SCL;
      7'd44: op = STEP_SCL_LO;
      // Read bit loop.
      7'd45: op = STEP_IN_BIT;
      7'd46: op = STEP_SCL_HI;
      7'd47: op = STEP_WAIT_SCL;
      7'd48: op = STEP_NEXT_IN;
      // Stop clock and acknowledge after a read.
      7'd49: op = STEP_SCL_HI;
      7'd50: op = STEP_WAIT_SCL;
      7'd51: op = STEP_SCL_LO;
      7'd52: op = STEP_SDA_LO;
      7'd53: op = STEP_UNTRI;
      7'd54: op = STEP_SCL_HI;
      7'd55: op = STEP_WAIT_SCL;
      7'd56: op = STEP_SCL_LO;
      7'd57: op = STEP_SDA_HI;
      7'd58: op = STEP_WAIT_SDA;
      7'd59: op = STEP_SCL_HI;
      7'd60: op = STEP_WAIT_SCL;
      7'd61: op = STEP_READ_END;
      default: op = STEP_IDLE;
    endcase
    return op;
  endfunction

endpackage

@@ sv/two_wire_register_access_master.sv @@
// Bit-level master for a two-wire register bus. Each input item is one tick:
// it carries the sampled SCL and SDA levels and, on an idle tick, may start a
// register read or write. The block steps a fixed waveform program one action
// per tick and returns one result item per tick with the pin drive levels,
// busy, a done pulse with its error flag, and the last byte read. The program
// lookup, the wait counter compare and the state update sit between the state
// registers and a two-entry output buffer, so a new item is accepted in every
// cycle while the buffer has room. device_address (address 0) and
// timeout_ticks (address 4) are written over the APB port; the user must
// write them only while the block is idle, which the block does not enforce.
module two_wire_register_access_master (
  input  logic       clk,
  input  logic       rst,
  // Configuration port.
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready,
  // Input channel.
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [7:0] reg_index,
  input  logic [7:0] write_value,
  input  logic       scl_in,
  input  logic       sda_in,
  // Output channel.
  output logic       out_valid,
  input  logic       out_stall,
  output logic       scl_out,
  output logic       sda_out,
  output logic       sda_drive,
  output logic       busy_res,
  output logic       done_res,
  output logic       error,
  output logic [7:0] read_data
);

  // Configuration registers.
  logic [6:0]  device_address;
  logic [15:0] timeout_ticks;

  // Transaction state.
  logic [6:0]  step_position, step_position_next;
  logic [1:0]  byte_number, byte_number_next;
  logic [2:0]  bit_count, bit_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [15:0] wait_count, wait_count_next;
  logic        timeout_seen, timeout_seen_next;
  logic [1:0]  ack_samples, ack_samples_next;
  logic        is_read, is_read_next;
  logic [7:0]  index_latch, index_latch_next;
  logic [7:0]  value_latch, value_latch_next;
  logic [7:0]  read_latch, read_latch_next;
  logic        pin_scl, pin_scl_next;
  logic        pin_sda, pin_sda_next;
  logic        pin_drive, pin_drive_next;

  // Output buffer: main register and skid entry.
  twra_pkg::result_t out_reg, skid_reg, result_new;
  logic              skid_valid;

  logic accept, take, cfg_write;
  twra_pkg::step_op_t cur_op;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !in_stall;
  assign take      = out_valid && !out_stall;
  assign cur_op    = twra_pkg::prog_op(step_position);

  // Register read data.
  always_comb begin
    case (paddr[2])
      twra_pkg::REG_DEVICE_ADDRESS: prdata = {25'd0, device_address};
      twra_pkg::REG_TIMEOUT_TICKS:  prdata = {16'd0, timeout_ticks};
      default:                      prdata = 32'd0;
    endcase
  end

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 7'd0;
      timeout_ticks  <= twra_pkg::TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        twra_pkg::REG_DEVICE_ADDRESS: device_address <= pwdata[6:0];
        twra_pkg::REG_TIMEOUT_TICKS:  timeout_ticks  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // One tick of the waveform program.
  always_comb begin
    logic        finish, fail, level, bb_go;
    logic [6:0]  bb_pos;
    logic [7:0]  bb_data;
    logic [15:0] wc_inc;
    logic [2:0]  bc_inc;
    logic [1:0]  bn_inc;

    step_position_next = step_position;
    byte_number_next   = byte_number;
    bit_count_next     = bit_count;
    shift_byte_next    = shift_byte;
    wait_count_next    = wait_count;
    timeout_seen_next  = timeout_seen;
    ack_samples_next   = ack_samples;
    is_read_next       = is_read;
    index_latch_next   = index_latch;
    value_latch_next   = value_latch;
    read_latch_next    = read_latch;
    pin_scl_next       = pin_scl;
    pin_sda_next       = pin_sda;
    pin_drive_next     = pin_drive;

    finish  = 1'b0;
    fail    = 1'b0;
    bb_go   = 1'b0;
    bb_pos  = twra_pkg::SEND_START;
    bb_data = 8'd0;
    level   = (cur_op == twra_pkg::STEP_WAIT_SCL) ? scl_in : sda_in;
    wc_inc  = wait_count + 16'd1;
    bc_inc  = bit_count + 3'd1;
    bn_inc  = byte_number + 2'd1;

    if (step_position == 7'd0) begin
      // Idle: a read or write request latches its operands.
      if (op == twra_pkg::REQ_READ || op == twra_pkg::REQ_WRITE) begin
        is_read_next     = (op == twra_pkg::REQ_READ);
        index_latch_next = reg_index;
        value_latch_next = write_value;
        byte_number_next = 2'd0;
        bb_go            = 1'b1;
        bb_data          = {1'b0, device_address} |
                           ((op == twra_pkg::REQ_READ) ? twra_pkg::READ_FLAG : 8'd0);
      end
    end else begin
      case (cur_op)
        twra_pkg::STEP_SCL_HI: begin
          pin_scl_next = 1'b1;
          step_position_next = step_position + 7'd1;
        end
        twra_pkg::STEP_SCL_LO: begin
          pin_scl_next = 1'b0;
          step_position_next = step_position + 7'd1;
        end
        twra_pkg::STEP_SDA_HI: begin
          pin_sda_next = 1'b1;
          step_position_next = step_position + 7'd1;
        end
        twra_pkg::STEP_SDA_LO: begin
          pin_sda_next = 1'b0;
          step_position_next = step_position + 7'd1;
        end
        twra_pkg::STEP_TRI: begin
          pin_drive_next = 1'b0;
          step_position_next = step_position + 7'd1;
        end
        twra_pkg::STEP_UNTRI: begin
          pin_drive_next = 1'b1;
          step_position_next = step_position + 7'd1;
        end
        twra_pkg::STEP_WAIT_SCL, twra_pkg::STEP_WAIT_SDA: begin
          // Wait for the line to read high, giving up after the timeout.
          if (level) begin
            wait_count_next = 16'd0;
            step_position_next = step_position + 7'd1;
          end else if (wc_inc >= timeout_ticks) begin
            timeout_seen_next = 1'b1;
            wait_count_next = 16'd0;
            step_position_next = step_position + 7'd1;
          end else begin
            wait_count_next = wc_inc;
          end
        end
        twra_pkg::STEP_OUT_BIT: begin
          // A zero bit skips the wait for SDA to rise.
          pin_sda_next = shift_byte[7];
          step_position_next = step_position + (shift_byte[7] ? 7'd1 : 7'd2);
        end
        twra_pkg::STEP_NEXT_OUT: begin
          pin_scl_next = 1'b0;
          shift_byte_next = {shift_byte[6:0], 1'b0};
          bit_count_next = bc_inc;
          step_position_next = (bc_inc != 3'd0) ? twra_pkg::SEND_LOOP
                                                : step_position + 7'd1;
        end
        twra_pkg::STEP_ACK1: begin
          ack_samples_next = {ack_samples[1], sda_in};
          step_position_next = step_position + 7'd1;
        end
        twra_pkg::STEP_ACK2: begin
          ack_samples_next = {sda_in, ack_samples[0]};
          step_position_next = step_position + 7'd1;
        end
        twra_pkg::STEP_SEND_END: begin
          // Check the byte, then move on to the next one or finish the transaction.
          pin_drive_next = 1'b1;
          if (timeout_seen || ack_samples != 2'b10) begin
            finish = 1'b1;
            fail   = 1'b1;
          end else begin
            byte_number_next = bn_inc;
            if (bn_inc == 2'd1) begin
              bb_go   = 1'b1;
              bb_data = index_latch;
            end else if (bn_inc == 2'd2 && is_read) begin
              bb_go  = 1'b1;
              bb_pos = twra_pkg::READ_START;
            end else if (bn_inc == 2'd2) begin
              bb_go   = 1'b1;
              bb_data = value_latch;
            end else begin
              finish = 1'b1;
            end
          end
        end
        twra_pkg::STEP_IN_BIT: begin
          shift_byte_next = {shift_byte[6:0], sda_in};
          step_position_next = step_position + 7'd1;
        end
        twra_pkg::STEP_NEXT_IN: begin
          pin_scl_next = 1'b0;
          bit_count_next = bc_inc;
          step_position_next = (bc_inc != 3'd0) ? twra_pkg::READ_LOOP
                                                : step_position + 7'd1;
        end
        twra_pkg::STEP_READ_END: begin
          pin_scl_next = 1'b0;
          finish = 1'b1;
          if (timeout_seen) fail = 1'b1;
          else read_latch_next = shift_byte;
        end
        default: begin
          step_position_next = 7'd0;
        end
      endcase
    end

    // Set up a new byte: entry point, data and cleared byte state.
    if (bb_go) begin
      step_position_next = bb_pos;
      shift_byte_next    = bb_data;
      bit_count_next     = 3'd0;
      wait_count_next    = 16'd0;
      timeout_seen_next  = 1'b0;
      ack_samples_next   = 2'd0;
    end

    if (finish) step_position_next = 7'd0;

    result_new.scl_out   = pin_scl_next;
    result_new.sda_out   = pin_sda_next;
    result_new.sda_drive = pin_drive_next;
    result_new.busy_res  = (step_position_next != 7'd0);
    result_new.done_res  = finish;
    result_new.error     = finish && fail;
    result_new.read_data = read_latch_next;
  end

  // State update on each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_position <= 7'd0;
      byte_number   <= 2'd0;
      bit_count     <= 3'd0;
      shift_byte    <= 8'd0;
      wait_count    <= 16'd0;
      timeout_seen  <= 1'b0;
      ack_samples   <= 2'd0;
      is_read       <= 1'b0;
      index_latch   <= 8'd0;
      value_latch   <= 8'd0;
      read_latch    <= 8'd0;
      pin_scl       <= 1'b1;
      pin_sda       <= 1'b1;
      pin_drive     <= 1'b1;
    end else if (accept) begin
      step_position <= step_position_next;
      byte_number   <= byte_number_next;
      bit_count     <= bit_count_next;
      shift_byte    <= shift_byte_next;
      wait_count    <= wait_count_next;
      timeout_seen  <= timeout_seen_next;
      ack_samples   <= ack_samples_next;
      is_read       <= is_read_next;
      index_latch   <= index_latch_next;
      value_latch   <= value_latch_next;
      read_latch    <= read_latch_next;
      pin_scl       <= pin_scl_next;
      pin_sda       <= pin_sda_next;
      pin_drive     <= pin_drive_next;
    end
  end

  // Output buffer: the skid entry catches an item while the output stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Result payloads.
  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_valid) out_reg <= skid_reg;
      else if (accept) out_reg <= result_new;
    end else if (accept) begin
      skid_reg <= result_new;
    end
  end

  assign scl_out   = out_reg.scl_out;
  assign sda_out   = out_reg.sda_out;
  assign sda_drive = out_reg.sda_drive;
  assign busy_res  = out_reg.busy_res;
  assign done_res  = out_reg.done_res;
  assign error     = out_reg.error;
  assign read_data = out_reg.read_data;

endmodule

@@ sim/testbench.sv @@
module testbench;

  // Unused request code, which the block treats as a plain tick.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int LONG_HOLD = 300;
  localparam int SHOW_LIMIT = 40;
  localparam int ITEM_TARGET = 750;

  // One input item: a tick with the sampled lines and an optional request.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] reg_index;
    logic [7:0] write_value;
    logic       scl_in;
    logic       sda_in;
  } tick_t;

  localparam int TICK_BITS = $bits(tick_t);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = 2'd0;
  logic [7:0]  reg_index = 8'd0;
  logic [7:0]  write_value = 8'd0;
  logic        scl_in = 1'b1;
  logic        sda_in = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        scl_out;
  logic        sda_out;
  logic        sda_drive;
  logic        busy_res;
  logic        done_res;
  logic        error;
  logic [7:0]  read_data;

  two_wire_register_access_master u_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .reg_index   (reg_index),
    .write_value (write_value),
    .scl_in      (scl_in),
    .sda_in      (sda_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .scl_out     (scl_out),
    .sda_out     (sda_out),
    .sda_drive   (sda_drive),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .error       (error),
    .read_data   (read_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the bus master state and its configuration.
  twra_pkg::step_op_t wave_prog [0:127];
  logic [6:0]  mst_pos = 7'd0;
  logic [1:0]  mst_byte = 2'd0;
  logic [2:0]  mst_bits = 3'd0;
  logic [7:0]  mst_shift = 8'd0;
  logic [15:0] mst_wait = 16'd0;
  logic        mst_tmo = 1'b0;
  logic [1:0]  mst_ack = 2'd0;
  logic        mst_rd = 1'b0;
  logic [7:0]  mst_index = 8'd0;
  logic [7:0]  mst_value = 8'd0;
  logic [7:0]  mst_rdata = 8'd0;
  logic        mst_scl = 1'b1;
  logic        mst_sda = 1'b1;
  logic        mst_drv = 1'b1;
  logic [6:0]  cfg_dev = 7'd0;
  logic [15:0] cfg_tmo = twra_pkg::TIMEOUT_RESET;

  twra_pkg::result_t pin_expect_q [$];

  int  errors = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  reads_started = 0;
  int  writes_started = 0;
  int  failed_transfers = 0;
  int  stall_cycles = 0;
  int  burst_left = 0;
  bit  no_gaps = 1'b0;
  bit  hold_req = 1'b0;

  // The waveform the master steps through, one action per position.
  initial begin : load_waveform
    twra_pkg::step_op_t steps [0:61];
    steps = '{twra_pkg::STEP_IDLE,
      twra_pkg::STEP_SDA_HI, twra_pkg::STEP_WAIT_SDA, twra_pkg::STEP_SCL_HI,
      twra_pkg::STEP_WAIT_SCL, twra_pkg::STEP_SCL_LO, twra_pkg::STEP_SCL_HI,
      twra_pkg::STEP_WAIT_SCL, twra_pkg::STEP_SCL_LO, twra_pkg::STEP_SDA_LO,
      twra_pkg::STEP_SCL_HI, twra_pkg::STEP_WAIT_SCL, twra_pkg::STEP_SCL_LO,
      twra_pkg::STEP_SCL_LO,
      twra_pkg::STEP_OUT_BIT, twra_pkg::STEP_WAIT_SDA, twra_pkg::STEP_SCL_HI,
      twra_pkg::STEP_WAIT_SCL, twra_pkg::STEP_NEXT_OUT,
      twra_pkg::STEP_SDA_HI, twra_pkg::STEP_WAIT_SDA, twra_pkg::STEP_SCL_HI,
      twra_pkg::STEP_WAIT_SCL, twra_pkg::STEP_SCL_LO,
      twra_pkg::STEP_TRI, twra_pkg::STEP_SCL_HI, twra_pkg::STEP_WAIT_SCL,
      twra_pkg::STEP_ACK1, twra_pkg::STEP_SCL_LO, twra_pkg::STEP_SCL_HI,
      twra_pkg::STEP_WAIT_SCL, twra_pkg::STEP_ACK2, twra_pkg::STEP_SCL_LO,
      twra_pkg::STEP_SCL_HI, twra_pkg::STEP_WAIT_SCL, twra_pkg::STEP_SEND_END,
      twra_pkg::STEP_TRI, twra_pkg::STEP_SCL_LO, twra_pkg::STEP_SCL_HI,
      twra_pkg::STEP_WAIT_SCL, twra_pkg::STEP_SCL_LO, twra_pkg::STEP_WAIT_SDA,
      twra_pkg::STEP_SCL_HI, twra_pkg::STEP_WAIT_SCL, twra_pkg::STEP_SCL_LO,
      twra_pkg::STEP_IN_BIT, twra_pkg::STEP_SCL_HI, twra_pkg::STEP_WAIT_SCL,
      twra_pkg::STEP_NEXT_IN,
      twra_pkg::STEP_SCL_HI, twra_pkg::STEP_WAIT_SCL, twra_pkg::STEP_SCL_LO,
      twra_pkg::STEP_SDA_LO, twra_pkg::STEP_UNTRI, twra_pkg::STEP_SCL_HI,
      twra_pkg::STEP_WAIT_SCL, twra_pkg::STEP_SCL_LO, twra_pkg::STEP_SDA_HI,
      twra_pkg::STEP_WAIT_SDA, twra_pkg::STEP_SCL_HI, twra_pkg::STEP_WAIT_SCL,
      twra_pkg::STEP_READ_END};
    foreach (wave_prog[i]) begin
      wave_prog[i] = (i < 62) ? steps[i] : twra_pkg::STEP_IDLE;
    end
  end

  task automatic report_mismatch(input string detail);
    errors++;
    if (errors <= SHOW_LIMIT) begin
      $display("mismatch at %0t: %s", $time, detail);
    end
  endtask

  // Load a byte to send or receive and clear the per-byte status.
  task automatic start_byte(input logic [6:0] pos, input logic [7:0] data);
    mst_pos = pos;
    mst_shift = data;
    mst_bits = 3'd0;
    mst_wait = 16'd0;
    mst_tmo = 1'b0;
    mst_ack = 2'd0;
  endtask

  // Wait for a line to read high, giving up after the timeout count.
  task automatic wait_for_line(input logic level);
    if (level) begin
      mst_wait = 16'd0;
      mst_pos = mst_pos + 7'd1;
    end else begin
      mst_wait = mst_wait + 16'd1;
      if (mst_wait >= cfg_tmo) begin
        mst_tmo = 1'b1;
        mst_wait = 16'd0;
        mst_pos = mst_pos + 7'd1;
      end
    end
  endtask

  // Advance the shadow master by one tick and return the pin levels it leaves.
  task automatic advance_master(input tick_t t, output twra_pkg::result_t r);
    logic done;
    logic fail;
    done = 1'b0;
    fail = 1'b0;
    if (mst_pos == 7'd0) begin
      if (t.op == twra_pkg::REQ_READ || t.op == twra_pkg::REQ_WRITE) begin
        mst_rd = (t.op == twra_pkg::REQ_READ);
        mst_index = t.reg_index;
        mst_value = t.write_value;
        mst_byte = 2'd0;
        start_byte(twra_pkg::SEND_START,
                   {1'b0, cfg_dev} | (mst_rd ? twra_pkg::READ_FLAG : 8'h00));
        if (mst_rd) reads_started++;
        else writes_started++;
      end
    end else begin
      case (wave_prog[mst_pos])
        twra_pkg::STEP_SCL_HI: begin
          mst_scl = 1'b1;
          mst_pos = mst_pos + 7'd1;
        end
        twra_pkg::STEP_SCL_LO: begin
          mst_scl = 1'b0;
          mst_pos = mst_pos + 7'd1;
        end
        twra_pkg::STEP_SDA_HI: begin
          mst_sda = 1'b1;
          mst_pos = mst_pos + 7'd1;
        end
        twra_pkg::STEP_SDA_LO: begin
          mst_sda = 1'b0;
          mst_pos = mst_pos + 7'd1;
        end
        twra_pkg::STEP_TRI: begin
          mst_drv = 1'b0;
          mst_pos = mst_pos + 7'd1;
        end
        twra_pkg::STEP_UNTRI: begin
          mst_drv = 1'b1;
          mst_pos = mst_pos + 7'd1;
        end
        twra_pkg::STEP_WAIT_SCL: wait_for_line(t.scl_in);
        twra_pkg::STEP_WAIT_SDA: wait_for_line(t.sda_in);
        twra_pkg::STEP_OUT_BIT: begin
          // A zero bit skips the wait for the data line to rise.
          mst_sda = mst_shift[7];
          mst_pos = mst_pos + (mst_shift[7] ? 7'd1 : 7'd2);
        end
        twra_pkg::STEP_NEXT_OUT: begin
          mst_scl = 1'b0;
          mst_shift = {mst_shift[6:0], 1'b0};
          mst_bits = mst_bits + 3'd1;
          mst_pos = (mst_bits != 3'd0) ? twra_pkg::SEND_LOOP : mst_pos + 7'd1;
        end
        twra_pkg::STEP_ACK1: begin
          mst_ack[0] = t.sda_in;
          mst_pos = mst_pos + 7'd1;
        end
        twra_pkg::STEP_ACK2: begin
          mst_ack[1] = t.sda_in;
          mst_pos = mst_pos + 7'd1;
        end
        twra_pkg::STEP_SEND_END: begin
          mst_drv = 1'b1;
          if (mst_tmo || mst_ack != 2'b10) begin
            done = 1'b1;
            fail = 1'b1;
          end else begin
            mst_byte = mst_byte + 2'd1;
            if (mst_byte == 2'd1) start_byte(twra_pkg::SEND_START, mst_index);
            else if (mst_byte == 2'd2 && mst_rd) start_byte(twra_pkg::READ_START, 8'h00);
            else if (mst_byte == 2'd2) start_byte(twra_pkg::SEND_START, mst_value);
            else done = 1'b1;
          end
        end
        twra_pkg::STEP_IN_BIT: begin
          mst_shift = {mst_shift[6:0], t.sda_in};
          mst_pos = mst_pos + 7'd1;
        end
        twra_pkg::STEP_NEXT_IN: begin
          mst_scl = 1'b0;
          mst_bits = mst_bits + 3'd1;
          mst_pos = (mst_bits != 3'd0) ? twra_pkg::READ_LOOP : mst_pos + 7'd1;
        end
        twra_pkg::STEP_READ_END: begin
          mst_scl = 1'b0;
          done = 1'b1;
          if (mst_tmo) fail = 1'b1;
          else mst_rdata = mst_shift;
        end
        default: mst_pos = 7'd0;
      endcase
      if (done) begin
        mst_pos = 7'd0;
        if (fail) failed_transfers++;
      end
    end
    r.scl_out = mst_scl;
    r.sda_out = mst_sda;
    r.sda_drive = mst_drv;
    r.busy_res = (mst_pos != 7'd0);
    r.done_res = done;
    r.error = fail;
    r.read_data = mst_rdata;
  endtask

  // Offer one item, in bursts with random gaps, and predict it once taken.
  task automatic send_item(input tick_t t);
    twra_pkg::result_t want;
    bit taken;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0 && !no_gaps) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    op <= t.op;
    reg_index <= t.reg_index;
    write_value <= t.write_value;
    scl_in <= t.scl_in;
    sda_in <= t.sda_in;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    advance_master(t, want);
    pin_expect_q.push_back(want);
    items_sent++;
  endtask

  // Line levels that a bus device would return for the next step.
  function automatic tick_t bus_reply(input int hold_pct, input int nak_pct,
                                      input bit noisy);
    tick_t t;
    t = TICK_BITS'($urandom);
    // Requests during a transfer should be ignored by the block.
    if ($urandom_range(0, 3) != 0) t.op = twra_pkg::REQ_TICK;
    if (!noisy) begin
      case (wave_prog[mst_pos])
        twra_pkg::STEP_WAIT_SCL: t.scl_in = ($urandom_range(0, 99) >= hold_pct);
        twra_pkg::STEP_WAIT_SDA: t.sda_in = ($urandom_range(0, 99) >= hold_pct);
        twra_pkg::STEP_ACK1:     t.sda_in = ($urandom_range(0, 99) < nak_pct);
        twra_pkg::STEP_ACK2:     t.sda_in = ($urandom_range(0, 99) >= nak_pct);
        default: ;
      endcase
    end
    return t;
  endfunction

  // A few idle ticks, one request, then bus replies until the transfer ends.
  task automatic run_transaction(input logic [1:0] req, input logic [7:0] idx,
                                 input logic [7:0] val, input int hold_pct,
                                 input int nak_pct, input bit noisy);
    tick_t t;
    repeat ($urandom_range(0, 2)) begin
      t = TICK_BITS'($urandom);
      t.op = $urandom_range(0, 1) ? REQ_UNUSED : twra_pkg::REQ_TICK;
      send_item(t);
    end
    t = TICK_BITS'($urandom);
    t.op = req;
    t.reg_index = idx;
    t.write_value = val;
    send_item(t);
    while (mst_pos != 7'd0) begin
      send_item(bus_reply(hold_pct, nak_pct, noisy));
    end
  endtask

  // Wait until every predicted result has come back, then a little longer.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pin_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register over APB, then read it back.
  task automatic write_config(input logic idx, input logic [31:0] value);
    bit taken;
    logic [31:0] readback;
    logic [31:0] stored;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      taken = pready;
      @(posedge clk);
    end while (!taken);
    if (idx == twra_pkg::REG_DEVICE_ADDRESS) begin
      cfg_dev = value[6:0];
      stored = {25'd0, cfg_dev};
    end else begin
      cfg_tmo = value[15:0];
      stored = {16'd0, cfg_tmo};
    end
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      taken = pready;
      readback = prdata;
      @(posedge clk);
    end while (!taken);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (readback !== stored) begin
      report_mismatch($sformatf("register %0d read %0h expected %0h", idx, readback, stored));
    end
  endtask

  // Results are compared at the falling edge before the edge that takes them.
  always @(negedge clk) begin : check_results
    twra_pkg::result_t want;
    if (!rst && in_valid && in_stall) stall_cycles++;
    if (!rst && out_valid && !out_stall) begin
      if (pin_expect_q.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        want = pin_expect_q.pop_front();
        results_seen++;
        if (scl_out !== want.scl_out)
          report_mismatch($sformatf("scl_out %0b expected %0b", scl_out, want.scl_out));
        if (sda_out !== want.sda_out)
          report_mismatch($sformatf("sda_out %0b expected %0b", sda_out, want.sda_out));
        if (sda_drive !== want.sda_drive)
          report_mismatch($sformatf("sda_drive %0b expected %0b", sda_drive, want.sda_drive));
        if (busy_res !== want.busy_res)
          report_mismatch($sformatf("busy_res %0b expected %0b", busy_res, want.busy_res));
        if (done_res !== want.done_res)
          report_mismatch($sformatf("done_res %0b expected %0b", done_res, want.done_res));
        if (error !== want.error)
          report_mismatch($sformatf("error %0b expected %0b", error, want.error));
        if (read_data !== want.read_data)
          report_mismatch($sformatf("read_data %0h expected %0h", read_data, want.read_data));
      end
    end
  end

  // Receiver stall pattern: random segments, plus a long hold on request.
  initial begin : stall_pattern
    int seg_left;
    int stall_pct;
    int hold_left;
    seg_left = 0;
    stall_pct = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(1, 40);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 90;
          endcase
        end
        seg_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // A clean transfer with the configuration left at its reset values.
  task automatic test_reset_values();
    run_transaction(twra_pkg::REQ_WRITE, 8'h00, 8'h00, 0, 0, 1'b0);
    drain_results();
  endtask

  // Field and register extremes on a clean transfer.
  task automatic test_extremes();
    write_config(twra_pkg::REG_DEVICE_ADDRESS, 32'h7F);
    write_config(twra_pkg::REG_TIMEOUT_TICKS, 32'd1);
    run_transaction(twra_pkg::REQ_READ, 8'hFF, 8'hFF, 0, 0, 1'b0);
    drain_results();
  endtask

  // The device never acknowledges, so the first byte ends with an error.
  task automatic test_missing_ack();
    run_transaction(twra_pkg::REQ_WRITE, 8'h3C, 8'hC3, 0, 100, 1'b0);
    drain_results();
  endtask

  // Lines held low with a zero timeout, which behaves as one tick.
  task automatic test_timeouts();
    write_config(twra_pkg::REG_TIMEOUT_TICKS, 32'd0);
    run_transaction(twra_pkg::REQ_WRITE, 8'h12, 8'h34, 100, 0, 1'b0);
    drain_results();
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    write_config(twra_pkg::REG_TIMEOUT_TICKS, 32'd1000);
    hold_req = 1'b1;
    no_gaps = 1'b1;
    run_transaction(twra_pkg::REQ_WRITE, 8'h77, 8'h88, 0, 100, 1'b0);
    no_gaps = 1'b0;
    drain_results();
  endtask

  // Random transfers over several register settings.
  task automatic test_random();
    logic [6:0] dev;
    logic [15:0] tmo;
    int kind;
    for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
      case (phase)
        0: begin
          dev = 7'($urandom);
          tmo = 16'($urandom_range(2, 6));
        end
        1: begin
          dev = 7'h00;
          tmo = 16'd1;
        end
        2: begin
          dev = 7'h7F;
          tmo = 16'hFFFF;
        end
        default: begin
          dev = 7'($urandom);
          tmo = 16'($urandom_range(1, 65535));
        end
      endcase
      write_config(twra_pkg::REG_DEVICE_ADDRESS, {25'd0, dev});
      write_config(twra_pkg::REG_TIMEOUT_TICKS, {16'd0, tmo});
      kind = $urandom_range(0, 19);
      // Mostly well-behaved devices, some flaky ones, some pure noise.
      if (kind < 12)
        run_transaction($urandom_range(0, 1) ? twra_pkg::REQ_READ : twra_pkg::REQ_WRITE,
                        8'($urandom), 8'($urandom), 0, 0, 1'b0);
      else if (kind < 17)
        run_transaction($urandom_range(0, 1) ? twra_pkg::REQ_READ : twra_pkg::REQ_WRITE,
                        8'($urandom), 8'($urandom), $urandom_range(5, 30),
                        $urandom_range(5, 20), 1'b0);
      else
        run_transaction($urandom_range(0, 1) ? twra_pkg::REQ_READ : twra_pkg::REQ_WRITE,
                        8'($urandom), 8'($urandom), 0, 0, 1'b1);
      drain_results();
    end
  endtask

  initial begin : watchdog
    #20000000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin : main
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_extremes();
    test_missing_ack();
    test_timeouts();
    test_backpressure();
    test_random();
    drain_results();
    $display("covered %0d items and %0d results: %0d reads, %0d writes, %0d failed",
             items_sent, results_seen, reads_started, writes_started, failed_transfers);
    $display("input held back on %0d cycles; registers at reset, extreme and random values",
             stall_cycles);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
